@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assertion macros
// concurrent assertion helpers for the scorer top level
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// explicit clock and active-low reset
`define HOSD_ASSERT_CLK(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// default clock and reset of the house style
`define HOSD_ASSERT(name, prop, msg) `HOSD_ASSERT_CLK(name, clk_i, rst_ni, prop, msg)

`endif

@@ hdl/hosd_pkg.sv @@
// ----------------------------------------------------------------------------
// hosd_pkg
// types, codes and constants of the histogram outlier scorer
// ----------------------------------------------------------------------------
package hosd_pkg;

  localparam int unsigned NUM_LANES    = 4;
  localparam int unsigned BINS_DEFAULT = 256;
  localparam int unsigned ADDR_W       = 8;
  localparam int unsigned ADDR_SPAN    = 256;
  localparam int unsigned SCORE_W      = 16;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned PROD_W       = 24;
  localparam int unsigned THR_W        = 24;
  localparam int unsigned SUM_W        = 18;
  localparam int unsigned CFG_W        = 32;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned STEP_W       = 3;

  typedef enum logic [2:0] {
    MODE_DETECT = 3'd0,
    MODE_TRAIN  = 3'd1,
    MODE_CALIB  = 3'd2,
    MODE_DUMP   = 3'd3,
    MODE_RESET  = 3'd4,
    MODE_LATCH  = 3'd5,
    MODE_LOAD   = 3'd6
  } mode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCORE_THR = 2'd0,
    CFG_DELTA_THR = 2'd1,
    CFG_WEIGHTS   = 2'd2,
    CFG_PENALTY   = 2'd3
  } cfg_idx_e;

  localparam logic [CFG_W-1:0]   WEIGHTS_RST = 32'h373A_5D32;
  localparam logic [SCORE_W-1:0] PENALTY_RST = 16'd5632;

  localparam logic [BYTE_W-1:0] BYTE_HDR  = 8'hFE;
  localparam logic [BYTE_W-1:0] BYTE_ACK  = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_TAIL = 8'hFF;
  localparam logic [BYTE_W-1:0] BYTE_HIT  = 8'h01;
  localparam logic [BYTE_W-1:0] BYTE_MISS = 8'h00;

  // telemetry sequencer steps
  localparam logic [STEP_W-1:0] DSTEP_IDLE = 3'd0;
  localparam logic [STEP_W-1:0] DSTEP_HDR  = 3'd1;
  localparam logic [STEP_W-1:0] DSTEP_B0   = 3'd2;
  localparam logic [STEP_W-1:0] DSTEP_B1   = 3'd3;
  localparam logic [STEP_W-1:0] DSTEP_B2   = 3'd4;
  localparam logic [STEP_W-1:0] DSTEP_TAIL = 3'd5;

  // per-stage request tag travelling alongside the lanes
  typedef struct packed {
    logic              vld;
    logic              detect;
    logic [BYTE_W-1:0] rbyte;
    logic [THR_W-1:0]  thr;
  } stage_t;

  function automatic logic [BYTE_W-1:0] telemetry_byte(input logic [STEP_W-1:0] step,
                                                       input logic [THR_W-1:0]  thr);
    logic [BYTE_W-1:0] b;
    case (step)
      DSTEP_HDR: b = BYTE_HDR;
      DSTEP_B0:  b = thr[7:0];
      DSTEP_B1:  b = thr[15:8];
      DSTEP_B2:  b = thr[23:16];
      default:   b = BYTE_TAIL;
    endcase
    return b;
  endfunction

endpackage

@@ hdl/hosd_if.sv @@
// ----------------------------------------------------------------------------
// hosd stream interfaces
// valid/ready channels for sensor frame requests and result bytes
// ----------------------------------------------------------------------------
interface hosd_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  mode;
  logic        frame_good;
  logic [7:0]  bin_addr_0;
  logic [7:0]  bin_addr_1;
  logic [7:0]  bin_addr_2;
  logic [7:0]  bin_addr_3;
  logic [7:0]  spike_delta_0;
  logic [7:0]  spike_delta_1;
  logic [7:0]  spike_delta_2;
  logic [7:0]  spike_delta_3;
  logic [1:0]  load_sensor;
  logic [15:0] load_score;

  modport source (
    output valid, mode, frame_good, bin_addr_0, bin_addr_1, bin_addr_2, bin_addr_3,
           spike_delta_0, spike_delta_1, spike_delta_2, spike_delta_3,
           load_sensor, load_score,
    input  ready
  );
  modport sink (
    input  valid, mode, frame_good, bin_addr_0, bin_addr_1, bin_addr_2, bin_addr_3,
           spike_delta_0, spike_delta_1, spike_delta_2, spike_delta_3,
           load_sensor, load_score,
    output ready
  );
endinterface

interface hosd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] result_byte;

  modport source (output valid, result_byte, input ready);
  modport sink (input valid, result_byte, output ready);
endinterface

@@ hdl/histogram_outlier_score_detector.sv @@
// ----------------------------------------------------------------------------
// histogram_outlier_score_detector
// four-lane histogram outlier scorer with latch, telemetry dump and bin load
// ----------------------------------------------------------------------------
//  port      | dir | carries
//  ----------+-----+---------------------------------------------------
//  req_i     | in  | frame request: mode, frame_good, bins, deltas, load
//  res_o     | out | result byte: verdict, latch ack or telemetry byte
//  cfg_*_i   | in  | register writes, index 0..3, no read-back
//
//  one request per cycle; a result is registered after each of these steps:
//  bin memory read, penalty and weight multiply, lane sum and compare
//  the output register holds a result until taken; while it is full and
//  not taken the whole pipeline holds and no request is accepted
//  reset clears control state and restores register defaults; bin scores
//  are undefined until loaded
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module histogram_outlier_score_detector #(
  parameter int unsigned BINS = hosd_pkg::BINS_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  hosd_req_if.sink                       req_i,
  hosd_res_if.source                     res_o,
  input  logic                           cfg_we_i,
  input  logic [hosd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [hosd_pkg::CFG_W-1:0]     cfg_wdata_i
);

  // configuration registers
  logic [hosd_pkg::THR_W-1:0]   score_thr_q;
  logic [hosd_pkg::CFG_W-1:0]   delta_thr_q;
  logic [hosd_pkg::CFG_W-1:0]   weights_q;
  logic [hosd_pkg::SCORE_W-1:0] penalty_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      score_thr_q <= '0;
      delta_thr_q <= '0;
      weights_q   <= hosd_pkg::WEIGHTS_RST;
      penalty_q   <= hosd_pkg::PENALTY_RST;
    end else if (cfg_we_i) begin
      case (hosd_pkg::cfg_idx_e'(cfg_idx_i))
        hosd_pkg::CFG_SCORE_THR: score_thr_q <= cfg_wdata_i[hosd_pkg::THR_W-1:0];
        hosd_pkg::CFG_DELTA_THR: delta_thr_q <= cfg_wdata_i;
        hosd_pkg::CFG_WEIGHTS:   weights_q   <= cfg_wdata_i;
        hosd_pkg::CFG_PENALTY:   penalty_q   <= cfg_wdata_i[hosd_pkg::SCORE_W-1:0];
        default: ;
      endcase
    end
  end

  // handshake and pipeline advance
  logic out_valid;
  logic [hosd_pkg::BYTE_W-1:0] out_byte;
  logic adv, accept;

  assign adv         = !out_valid || res_o.ready;
  assign accept      = req_i.valid && adv;
  assign req_i.ready = adv;

  // control state
  logic                          armed_q, armed_d;
  logic [hosd_pkg::STEP_W-1:0]   dump_step_q, dump_step_d;
  logic [hosd_pkg::THR_W-1:0]    latched_q, latched_d;
  hosd_pkg::stage_t              s1_d, s1_q, s2_q;
  logic                          load_en;

  always_comb begin
    armed_d     = armed_q;
    dump_step_d = dump_step_q;
    latched_d   = latched_q;
    load_en     = 1'b0;
    s1_d        = '0;
    s1_d.thr    = latched_q;
    if (accept) begin
      if (hosd_pkg::mode_e'(req_i.mode) == hosd_pkg::MODE_DUMP) begin
        // dump bytes go out even on a bad frame
        if (dump_step_q != hosd_pkg::DSTEP_IDLE) begin
          s1_d.vld    = 1'b1;
          s1_d.rbyte  = hosd_pkg::telemetry_byte(dump_step_q, latched_q);
          dump_step_d = (dump_step_q >= hosd_pkg::DSTEP_TAIL) ? hosd_pkg::DSTEP_IDLE
                                                              : dump_step_q +
                                                                hosd_pkg::STEP_W'(1);
        end
      end else if (req_i.frame_good) begin
        case (hosd_pkg::mode_e'(req_i.mode))
          hosd_pkg::MODE_DETECT: begin
            s1_d.vld    = armed_q;
            s1_d.detect = 1'b1;
          end
          hosd_pkg::MODE_TRAIN: begin
            armed_d = 1'b0;
          end
          hosd_pkg::MODE_RESET: begin
            armed_d     = 1'b0;
            dump_step_d = hosd_pkg::DSTEP_IDLE;
            latched_d   = '0;
          end
          hosd_pkg::MODE_LATCH: begin
            armed_d    = 1'b1;
            latched_d  = score_thr_q;
            s1_d.vld   = 1'b1;
            s1_d.rbyte = hosd_pkg::BYTE_ACK;
            if (dump_step_q == hosd_pkg::DSTEP_IDLE) begin
              dump_step_d = hosd_pkg::DSTEP_HDR;
            end
          end
          hosd_pkg::MODE_LOAD: begin
            load_en = 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= 1'b0;
      dump_step_q <= hosd_pkg::DSTEP_IDLE;
      latched_q   <= '0;
      s1_q        <= '0;
      s2_q        <= '0;
    end else begin
      armed_q     <= armed_d;
      dump_step_q <= dump_step_d;
      latched_q   <= latched_d;
      if (adv) begin
        s1_q <= s1_d;
        s2_q <= s1_q;
      end
    end
  end

  // sensor lanes
  logic [hosd_pkg::ADDR_W-1:0]  lane_addr  [hosd_pkg::NUM_LANES];
  logic [hosd_pkg::BYTE_W-1:0]  lane_delta [hosd_pkg::NUM_LANES];
  logic [hosd_pkg::SCORE_W-1:0] lane_prod  [hosd_pkg::NUM_LANES];

  assign lane_addr[0]  = req_i.bin_addr_0;
  assign lane_addr[1]  = req_i.bin_addr_1;
  assign lane_addr[2]  = req_i.bin_addr_2;
  assign lane_addr[3]  = req_i.bin_addr_3;
  assign lane_delta[0] = req_i.spike_delta_0;
  assign lane_delta[1] = req_i.spike_delta_1;
  assign lane_delta[2] = req_i.spike_delta_2;
  assign lane_delta[3] = req_i.spike_delta_3;

  for (genvar l = 0; l < hosd_pkg::NUM_LANES; l++) begin : g_lane
    hosd_lane #(
      .BINS (BINS)
    ) u_lane (
      .clk_i       (clk_i),
      .rd_en_i     (accept),
      .rd_addr_i   (lane_addr[l]),
      .delta_i     (lane_delta[l]),
      .delta_thr_i (delta_thr_q[l*hosd_pkg::BYTE_W +: hosd_pkg::BYTE_W]),
      .wr_en_i     (load_en && (req_i.load_sensor == 2'(l))),
      .wr_addr_i   (req_i.bin_addr_0),
      .wr_data_i   (req_i.load_score),
      .adv_i       (adv),
      .penalty_i   (penalty_q),
      .weight_i    (weights_q[l*hosd_pkg::BYTE_W +: hosd_pkg::BYTE_W]),
      .prod_o      (lane_prod[l])
    );
  end

  hosd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .s2_i        (s2_q),
    .prod_i      (lane_prod),
    .out_valid_o (out_valid),
    .out_byte_o  (out_byte)
  );

  assign res_o.valid       = out_valid;
  assign res_o.result_byte = out_byte;

  // request decode for the checks below
  logic req_reset, req_latch, req_idle_dump;
  logic state_cleared, latch_taken;

  assign req_reset     = accept && req_i.frame_good && (req_i.mode == hosd_pkg::MODE_RESET);
  assign req_latch     = accept && req_i.frame_good && (req_i.mode == hosd_pkg::MODE_LATCH);
  assign req_idle_dump = accept && (req_i.mode == hosd_pkg::MODE_DUMP) &&
                         (dump_step_q == hosd_pkg::DSTEP_IDLE);
  assign state_cleared = !armed_q && (dump_step_q == hosd_pkg::DSTEP_IDLE) && (latched_q == '0);
  assign latch_taken   = armed_q && (dump_step_q != hosd_pkg::DSTEP_IDLE) && s1_q.vld;

  `HOSD_ASSERT(a_stall_holds, !adv |=> $stable(s1_q) && $stable(s2_q), "pipeline moved in stall")
  `HOSD_ASSERT(a_reset_clears, req_reset |=> state_cleared, "reset request left state")
  `HOSD_ASSERT(a_latch_arms, req_latch |=> latch_taken, "latch did not arm")
  `HOSD_ASSERT(a_idle_dump_silent, req_idle_dump |=> !s1_q.vld, "idle dump gave a result")

endmodule

@@ hdl/hosd_lane.sv @@
// ----------------------------------------------------------------------------
// hosd_lane
// one sensor lane: bin score memory, spike penalty and weight multiply
// ----------------------------------------------------------------------------
module hosd_lane #(
  parameter int unsigned BINS = hosd_pkg::BINS_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rd_en_i,
  input  logic [hosd_pkg::ADDR_W-1:0]        rd_addr_i,
  input  logic [hosd_pkg::BYTE_W-1:0]        delta_i,
  input  logic [hosd_pkg::BYTE_W-1:0]        delta_thr_i,
  input  logic                               wr_en_i,
  input  logic [hosd_pkg::ADDR_W-1:0]        wr_addr_i,
  input  logic [hosd_pkg::SCORE_W-1:0]       wr_data_i,
  input  logic                               adv_i,
  input  logic [hosd_pkg::SCORE_W-1:0]       penalty_i,
  input  logic [hosd_pkg::BYTE_W-1:0]        weight_i,
  output logic [hosd_pkg::SCORE_W-1:0]       prod_o
);

  localparam int unsigned IDX_W = (BINS > 1) ? $clog2(BINS) : 1;

  // bin index folding, address modulo bin count
  logic [IDX_W-1:0] fold [hosd_pkg::ADDR_SPAN];

  for (genvar a = 0; a < hosd_pkg::ADDR_SPAN; a++) begin : g_fold
    localparam int unsigned FOLDED = a % BINS;
    assign fold[a] = IDX_W'(FOLDED);
  end

  logic [hosd_pkg::SCORE_W-1:0] mem [BINS];
  logic [hosd_pkg::SCORE_W-1:0] score_q;
  logic                         spike_q;
  logic [hosd_pkg::SCORE_W-1:0] boosted;
  logic [hosd_pkg::PROD_W-1:0]  product;
  logic [hosd_pkg::SCORE_W-1:0] prod_d, prod_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[fold[wr_addr_i]] <= wr_data_i;
    end
    if (rd_en_i) begin
      score_q <= mem[fold[rd_addr_i]];
      spike_q <= (delta_i > delta_thr_i);
    end
  end

  always_comb begin
    boosted = score_q + (spike_q ? penalty_i : '0);
    product = hosd_pkg::PROD_W'(boosted) * hosd_pkg::PROD_W'(weight_i);
    prod_d  = product[hosd_pkg::PROD_W-1:hosd_pkg::BYTE_W];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q <= prod_d;
    end
  end

  assign prod_o = prod_q;

endmodule

@@ hdl/hosd_merge.sv @@
// ----------------------------------------------------------------------------
// hosd_merge
// sums the lane products, compares with the threshold, holds the result
// ----------------------------------------------------------------------------
module hosd_merge (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         adv_i,
  input  hosd_pkg::stage_t             s2_i,
  input  logic [hosd_pkg::SCORE_W-1:0] prod_i [hosd_pkg::NUM_LANES],
  output logic                         out_valid_o,
  output logic [hosd_pkg::BYTE_W-1:0]  out_byte_o
);

  logic [hosd_pkg::SUM_W-1:0]  sum;
  logic                        hit;
  logic [hosd_pkg::BYTE_W-1:0] byte_d, byte_q;
  logic                        vld_q;

  always_comb begin
    sum = '0;
    for (int l = 0; l < hosd_pkg::NUM_LANES; l++) begin
      sum = sum + hosd_pkg::SUM_W'(prod_i[l]);
    end
    hit    = (hosd_pkg::THR_W'(sum) >= s2_i.thr);
    byte_d = s2_i.detect ? (hit ? hosd_pkg::BYTE_HIT : hosd_pkg::BYTE_MISS) : s2_i.rbyte;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= s2_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      byte_q <= byte_d;
    end
  end

  assign out_valid_o = vld_q;
  assign out_byte_o  = byte_q;

endmodule
